FILE: rtl/core/bre_pkg.sv
// Shared types, constants and helpers for the bitmap run to extent block.
// Used by every module under rtl/core; depends on nothing.
package bre_pkg;

    localparam int INDEX_BITS  = 36;
    localparam int ESIZE_W     = 25;
    localparam int OUT_W       = 60;
    localparam int MAX_RANGES  = 5;
    localparam int RCNT_W      = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int BITS_PER_BYTE = 8;
    localparam int STEP_W      = 4;

    localparam logic [ESIZE_W-1:0] ESIZE_RESET = ESIZE_W'(4096);

    // multiplier split of the index operand
    localparam int HALF_LO  = (INDEX_BITS + 1) / 2;
    localparam int HALF_HI  = INDEX_BITS - HALF_LO;
    localparam int PROD_W   = INDEX_BITS + ESIZE_W;
    localparam int SUM_W    = (PROD_W > OUT_W) ? PROD_W : OUT_W + 1;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    typedef logic [INDEX_BITS-1:0] t_index;

    // ranges closed by one byte, as element index pairs
    typedef struct packed {
        logic [RCNT_W-1:0]             count;
        logic [MAX_RANGES-1:0][INDEX_BITS-1:0] start_idx;
        logic [MAX_RANGES-1:0][INDEX_BITS-1:0] stop_idx;
    } t_rec;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // index plus a small step, saturating at the top index
    function automatic t_index sat_index_add(input t_index base, input logic [STEP_W-1:0] k);
        logic [INDEX_BITS:0] sum;
        sum = {1'b0, base} + {{(INDEX_BITS + 1 - STEP_W){1'b0}}, k};
        return sum[INDEX_BITS] ? {INDEX_BITS{1'b1}} : sum[INDEX_BITS-1:0];
    endfunction

endpackage

FILE: rtl/core/bre_ifs.sv
// Valid/ready channel interfaces for the bitmap run to extent block.
// Depends on bre_pkg for field widths.
interface bre_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] bitmap_byte;
    logic       end_of_buffer;
    logic       restart;
    modport source (output valid, bitmap_byte, end_of_buffer, restart, input ready);
    modport sink   (input valid, bitmap_byte, end_of_buffer, restart, output ready);
endinterface

interface bre_out_if;
    logic                     valid;
    logic                     ready;
    logic [bre_pkg::OUT_W-1:0] range_offset;
    logic [bre_pkg::OUT_W-1:0] range_size;
    logic                     last_of_item;
    modport source (output valid, range_offset, range_size, last_of_item, input ready);
    modport sink   (input valid, range_offset, range_size, last_of_item, output ready);
endinterface

interface bre_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bre_pkg::ESIZE_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/bre_front.sv
// Front end: accepts bitmap bytes, tracks the open run and element count,
// and packs the ranges each byte closes into one record. Depends on bre_pkg.
module bre_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bre_in_if.sink            i_in,
    input  bre_pkg::t_qstat   i_qstat,
    output bre_pkg::t_push    o_push
);

    logic              r_run_open;
    bre_pkg::t_index   r_run_start;
    bre_pkg::t_index   r_count;
    logic              n_run_open;
    bre_pkg::t_index   n_run_start;
    bre_pkg::t_index   n_count;
    bre_pkg::t_rec     rec;
    logic              accept;

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        bre_pkg::t_index   base;
        bre_pkg::t_index   idx;
        logic [bre_pkg::RCNT_W-1:0] n;
        logic              open;
        bre_pkg::t_index   start;
        base  = i_in.restart ? '0 : r_count;
        open  = i_in.restart ? 1'b0 : r_run_open;
        start = i_in.restart ? '0 : r_run_start;
        n     = '0;
        rec   = '0;
        for (int b = 0; b < bre_pkg::BITS_PER_BYTE; b++) begin
            idx = bre_pkg::sat_index_add(base, bre_pkg::STEP_W'(b));
            if (!open && i_in.bitmap_byte[b]) begin
                open  = 1'b1;
                start = idx;
            end else if (open && !i_in.bitmap_byte[b]) begin
                rec.start_idx[n] = start;
                rec.stop_idx[n]  = idx;
                n    = n + 1'b1;
                open = 1'b0;
            end
        end
        n_count = bre_pkg::sat_index_add(base, bre_pkg::STEP_W'(bre_pkg::BITS_PER_BYTE));
        // flush an open run at the buffer end
        if (i_in.end_of_buffer && open) begin
            rec.start_idx[n] = start;
            rec.stop_idx[n]  = n_count;
            n    = n + 1'b1;
            open = 1'b0;
        end
        rec.count   = n;
        n_run_open  = open;
        n_run_start = start;
    end

    assign o_push.valid = accept && (rec.count != '0);
    assign o_push.rec   = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open  <= 1'b0;
            r_run_start <= '0;
            r_count     <= '0;
        end else if (accept) begin
            r_run_open  <= n_run_open;
            r_run_start <= n_run_start;
            r_count     <= n_count;
        end
    end

endmodule

FILE: rtl/core/bre_queue.sv
// Short record queue between front and back end, held in flip-flops.
// Depends on bre_pkg.
module bre_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bre_pkg::t_push    i_push,
    input  logic              i_pop,
    output bre_pkg::t_rec     o_head,
    output bre_pkg::t_qstat   o_qstat
);

    bre_pkg::t_rec                r_mem [bre_pkg::QUEUE_DEPTH];
    logic [bre_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [bre_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [bre_pkg::QPTR_W:0]     r_fill;
    logic                         do_push;
    logic                         do_pop;

    assign o_qstat.full  = (r_fill == (bre_pkg::QPTR_W + 1)'(bre_pkg::QUEUE_DEPTH));
    assign o_qstat.empty = (r_fill == '0);
    assign do_push = i_push.valid && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

FILE: rtl/core/bre_back.sv
// Back end: walks the ranges of the head record, scales index and length by
// the element size in split multipliers, saturates, and registers the result.
// Depends on bre_pkg.
module bre_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bre_pkg::ESIZE_W-1:0] i_element_size,
    input  bre_pkg::t_rec               i_head,
    input  bre_pkg::t_qstat             i_qstat,
    output logic                        o_pop,
    bre_out_if.source                   o_out
);

    localparam int LO_P = bre_pkg::HALF_LO + bre_pkg::ESIZE_W;
    localparam int HI_P = bre_pkg::HALF_HI + bre_pkg::ESIZE_W;

    logic [bre_pkg::RCNT_W-1:0] r_sel;
    logic                       advance;
    logic                       sel_last;

    // stage A: selected range
    logic            r_a_valid;
    logic            r_a_last;
    bre_pkg::t_index r_a_start;
    bre_pkg::t_index r_a_len;

    // stage B: partial products
    logic            r_b_valid;
    logic            r_b_last;
    logic [LO_P-1:0] r_b_start_lo;
    logic [HI_P-1:0] r_b_start_hi;
    logic [LO_P-1:0] r_b_len_lo;
    logic [HI_P-1:0] r_b_len_hi;

    // output register
    logic                      r_out_valid;
    logic                      r_out_last;
    logic [bre_pkg::OUT_W-1:0] r_out_offset;
    logic [bre_pkg::OUT_W-1:0] r_out_size;

    logic [bre_pkg::OUT_W-1:0] n_offset;
    logic [bre_pkg::OUT_W-1:0] n_size;

    function automatic logic [bre_pkg::OUT_W-1:0] combine_sat(input logic [LO_P-1:0] lo,
                                                              input logic [HI_P-1:0] hi);
        logic [bre_pkg::SUM_W-1:0] sum;
        sum = bre_pkg::SUM_W'(lo) + (bre_pkg::SUM_W'(hi) << bre_pkg::HALF_LO);
        return (|sum[bre_pkg::SUM_W-1:bre_pkg::OUT_W]) ? bre_pkg::OUT_MAX
                                                       : sum[bre_pkg::OUT_W-1:0];
    endfunction

    // whole pipe moves when the output register is free or being drained
    assign advance  = !r_out_valid || o_out.ready;
    assign sel_last = (r_sel == (i_head.count - 1'b1));
    assign o_pop    = advance && !i_qstat.empty && sel_last;

    assign n_offset = combine_sat(r_b_start_lo, r_b_start_hi);
    assign n_size   = combine_sat(r_b_len_lo, r_b_len_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            if (!i_qstat.empty) begin
                r_sel <= sel_last ? '0 : r_sel + 1'b1;
            end
            r_a_valid   <= !i_qstat.empty;
            r_b_valid   <= r_a_valid;
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_last  <= sel_last;
            r_a_start <= i_head.start_idx[r_sel];
            r_a_len   <= i_head.stop_idx[r_sel] - i_head.start_idx[r_sel];

            r_b_last     <= r_a_last;
            r_b_start_lo <= r_a_start[bre_pkg::HALF_LO-1:0] * i_element_size;
            r_b_start_hi <= r_a_start[bre_pkg::INDEX_BITS-1:bre_pkg::HALF_LO] * i_element_size;
            r_b_len_lo   <= r_a_len[bre_pkg::HALF_LO-1:0] * i_element_size;
            r_b_len_hi   <= r_a_len[bre_pkg::INDEX_BITS-1:bre_pkg::HALF_LO] * i_element_size;

            r_out_last   <= r_b_last;
            r_out_offset <= n_offset;
            r_out_size   <= n_size;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.last_of_item = r_out_last;
    assign o_out.range_offset = r_out_offset;
    assign o_out.range_size   = r_out_size;

endmodule

FILE: rtl/core/bitmap_run_to_extent.sv
// Bitmap run to extent: one bitmap byte accepted per cycle; a range goes via
// stage A, stage B and the output register, one range per cycle unless stalled.
// A byte closing several ranges holds one slot of the 4-entry record queue, so
// input stalls only when the single-range-per-cycle back end falls behind.
// Synchronous active-low reset clears run state, element count and queue and
// sets element size to 4096. Depends on bre_pkg, bre_ifs, front, queue, back.
module bitmap_run_to_extent (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bre_in_if.sink     i_in,
    bre_cfg_if.sink    i_cfg,
    bre_out_if.source  o_out
);

    logic [bre_pkg::ESIZE_W-1:0] r_element_size;
    bre_pkg::t_push              push;
    bre_pkg::t_rec               head;
    bre_pkg::t_qstat             qstat;
    logic                        pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_size <= bre_pkg::ESIZE_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_element_size <= i_cfg.data;
        end
    end

    bre_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (qstat),
        .o_push  (push)
    );

    bre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    bre_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_element_size (r_element_size),
        .i_head         (head),
        .i_qstat        (qstat),
        .o_pop          (pop),
        .o_out          (o_out)
    );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking bench for bitmap_run_to_extent: directed bitmap bytes, then random ones
// under several element sizes, with an in-bench extent predictor and random stalls.
// Depends on bre_pkg, the bre_*_if interfaces and the bitmap_run_to_extent top level.
module tb_top;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 58;
    localparam int MAX_GAP     = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 16;

    typedef logic [bre_pkg::INDEX_BITS-1:0] t_idx;
    typedef logic [bre_pkg::ESIZE_W-1:0]    t_esize;
    typedef logic [bre_pkg::OUT_W-1:0]      t_bytes;

    typedef struct {
        t_bytes off;
        t_bytes len;
        logic   last;
    } t_extent;

    // directed stimulus; rows with known_ext carry their extent typed in
    typedef struct {
        logic [7:0] bits;
        logic       eob;
        logic       rst;
        logic       known_ext;
        int         n_ext;
        t_bytes     off;
        t_bytes     len;
    } t_row;

    localparam int DIR_ROWS = 19;

    t_row dir_rows [0:DIR_ROWS-1] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 0, 60'd0,     60'd0},
        '{8'hFF, 1'b1, 1'b0, 1'b1, 1, 60'd32768, 60'd32768},
        '{8'h01, 1'b0, 1'b0, 1'b1, 1, 60'd65536, 60'd4096},
        '{8'h55, 1'b0, 1'b0, 1'b0, 0, 60'd0,     60'd0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 0, 60'd0,     60'd0},
        '{8'hAA, 1'b1, 1'b0, 1'b0, 0, 60'd0,     60'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 0, 60'd0,     60'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 0, 60'd0,     60'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 0, 60'd0,     60'd0},
        '{8'hF0, 1'b0, 1'b0, 1'b0, 0, 60'd0,     60'd0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 0, 60'd0,     60'd0},
        '{8'h03, 1'b0, 1'b0, 1'b1, 1, 60'd32768, 60'd8192},
        '{8'hFF, 1'b1, 1'b1, 1'b1, 1, 60'd0,     60'd32768},
        '{8'h00, 1'b1, 1'b0, 1'b1, 0, 60'd0,     60'd0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 0, 60'd0,     60'd0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 0, 60'd0,     60'd0},
        '{8'hFE, 1'b1, 1'b0, 1'b0, 0, 60'd0,     60'd0},
        '{8'h00, 1'b1, 1'b1, 1'b1, 0, 60'd0,     60'd0},
        '{8'h81, 1'b0, 1'b0, 1'b0, 0, 60'd0,     60'd0}
    };

    logic clk;
    logic rst_n;

    bre_in_if  in_ch ();
    bre_cfg_if cfg_ch ();
    bre_out_if out_ch ();

    bitmap_run_to_extent uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // predictor state
    t_esize elem_size;
    logic   run_live;
    t_idx   run_base;
    t_idx   elem_count;

    t_extent extent_q [$];
    t_extent fresh_q [$];

    int  mismatches;
    int  extents_seen;
    int  bytes_sent;
    int  size_writes;
    int  cycles;
    bit  sender_idle;
    bit  sink_idle;
    bit  hold_out;

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // index times element size, clamped to the 60-bit output range
    function automatic t_bytes scale_to_bytes(input t_idx idx, input t_esize esz);
        logic [bre_pkg::INDEX_BITS+bre_pkg::ESIZE_W-1:0] prod;
        prod = {{bre_pkg::ESIZE_W{1'b0}}, idx} * {{bre_pkg::INDEX_BITS{1'b0}}, esz};
        if (prod > {1'b0, bre_pkg::OUT_MAX})
            return bre_pkg::OUT_MAX;
        return prod[bre_pkg::OUT_W-1:0];
    endfunction

    function automatic void close_run(input t_idx stop_idx);
        t_extent ext;
        ext.off  = scale_to_bytes(run_base, elem_size);
        ext.len  = scale_to_bytes(stop_idx - run_base, elem_size);
        ext.last = 1'b0;
        fresh_q.push_back(ext);
        run_live = 1'b0;
    endfunction

    // walk one bitmap byte and leave the extents it closes in fresh_q
    function automatic void bitmap_to_extents(input logic [7:0] bits, input logic eob,
                                              input logic rst);
        fresh_q.delete();
        if (rst) begin
            elem_count = '0;
            run_live   = 1'b0;
            run_base   = '0;
        end
        for (int b = 0; b < bre_pkg::BITS_PER_BYTE; b++) begin
            if (!run_live) begin
                if (bits[b]) begin
                    run_live = 1'b1;
                    run_base = elem_count;
                end
            end else if (!bits[b]) begin
                close_run(elem_count);
            end
            if (elem_count != {bre_pkg::INDEX_BITS{1'b1}})
                elem_count++;
        end
        if (eob && run_live)
            close_run(elem_count);
        if (fresh_q.size() > 0)
            fresh_q[fresh_q.size()-1].last = 1'b1;
    endfunction

    // present one byte after gap idle cycles, hold until the transfer, predict
    task automatic feed(input logic [7:0] bits, input logic eob, input logic rst, input int gap,
                        input t_row row);
        t_extent ext;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.bitmap_byte   <= bits;
        in_ch.end_of_buffer <= eob;
        in_ch.restart       <= rst;
        do @(posedge clk); while (!in_ch.ready);
        bytes_sent++;
        bitmap_to_extents(bits, eob, rst);
        if (row.known_ext) begin
            for (int k = 0; k < row.n_ext; k++) begin
                ext.off  = row.off;
                ext.len  = row.len;
                ext.last = (k == row.n_ext - 1);
                extent_q.push_back(ext);
            end
        end else begin
            foreach (fresh_q[k])
                extent_q.push_back(fresh_q[k]);
        end
    endtask

    // drain everything, let bytes without extents clear the pipe, then write
    task automatic set_element_size(input t_esize value);
        in_ch.valid <= 1'b0;
        while (extent_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        elem_size = value;
        size_writes++;
    endtask

    function automatic logic [7:0] pick_bits();
        int lo;
        int hi;
        lo = $urandom_range(0, 7);
        hi = $urandom_range(lo, 7);
        case ($urandom_range(0, 7))
            3: return 8'hFF;
            4: return 8'h00;
            5: return (8'hFF << lo) & (8'hFF >> (7 - hi));
            6: return $urandom_range(0, 1) ? 8'h55 : 8'hAA;
            7: return 8'($urandom) & 8'($urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int draw_gap(input bit idle_on);
        return idle_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d extents outstanding", cycles,
                     extent_q.size());
            $display("bitmap_run_to_extent test failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        t_extent want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (extent_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected extent: off=%0d size=%0d last=%0b",
                             out_ch.range_offset, out_ch.range_size, out_ch.last_of_item);
            end else begin
                want = extent_q.pop_front();
                extents_seen++;
                if (out_ch.range_offset !== want.off || out_ch.range_size !== want.len ||
                    out_ch.last_of_item !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"extent %0d: expected off=%0d size=%0d last=%0b, ",
                                  "got off=%0d size=%0d last=%0b"},
                                 extents_seen, want.off, want.len, want.last,
                                 out_ch.range_offset, out_ch.range_size, out_ch.last_of_item);
                end
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_out) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_out = 1'b0;
            end
            gap = draw_gap(sink_idle);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    initial begin
        t_esize size_plan [0:PHASES-1];
        t_row   no_row;
        int     gap;

        no_row = '{8'h00, 1'b0, 1'b0, 1'b0, 0, 60'd0, 60'd0};
        size_plan = '{25'd4096, 25'd1, 25'h1000000, 25'd0, 25'h1FFFFFF,
                      t_esize'($urandom_range(2, 16777215)), 25'd4096};

        mismatches   = 0;
        extents_seen = 0;
        bytes_sent   = 0;
        size_writes  = 0;
        sender_idle  = 1'b1;
        sink_idle    = 1'b1;
        hold_out     = 1'b0;

        elem_size  = bre_pkg::ESIZE_RESET;
        run_live   = 1'b0;
        run_base   = '0;
        elem_count = '0;

        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.bitmap_byte   <= '0;
        in_ch.end_of_buffer <= 1'b0;
        in_ch.restart       <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
            feed(dir_rows[r].bits, dir_rows[r].eob, dir_rows[r].rst, draw_gap(1'b1),
                 dir_rows[r]);

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0)
                set_element_size(size_plan[p]);
            // one phase runs back to back on both sides
            sender_idle = (p != 4);
            sink_idle   = (p != 4);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == 10)
                    hold_out = 1'b1;
                if (p == 3 && i == 30) begin
                    in_ch.valid <= 1'b0;
                    do @(posedge clk); while (extent_q.size() != 0);
                end
                // keep offering while the result side is held off
                gap = (p == 2 && i >= 10 && i < 50) ? 0 : draw_gap(sender_idle);
                feed(pick_bits(), $urandom_range(0, 3) == 0, $urandom_range(0, 15) == 0, gap,
                     no_row);
            end
        end

        in_ch.valid <= 1'b0;
        while (extent_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d bitmap bytes, checked %0d extents, %0d element size writes",
                 bytes_sent, extents_seen, size_writes);
        $display("Sizes included 0, 1, 2^24 and all-ones; one long output hold-off; %0d errors",
                 mismatches);
        if (mismatches == 0 && extent_q.size() == 0)
            $display("bitmap_run_to_extent test passed");
        else
            $display("bitmap_run_to_extent test failed");
        $finish;
    end

endmodule

FILE: bitmap_run_to_extent.f
rtl/core/bre_pkg.sv
rtl/core/bre_ifs.sv
rtl/core/bre_front.sv
rtl/core/bre_queue.sv
rtl/core/bre_back.sv
rtl/core/bitmap_run_to_extent.sv
tb/sv/tb_top.sv
